// ----- hw/rtl/afe_pkg.sv -----
// Package for the assignment fitness evaluator: sizes, command codes and
// the penalty weight. No dependencies; used by assignment_fitness_eval.
package afe_pkg;

  localparam int unsigned MaxAgents = 16;
  localparam int unsigned MaxTasks  = 256;
  localparam int unsigned AgentW    = $clog2(MaxAgents);
  localparam int unsigned TaskW     = $clog2(MaxTasks);
  localparam int unsigned AddrW     = AgentW + TaskW;
  localparam int unsigned TableDepth = MaxAgents * MaxTasks;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned LoadW    = 24;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned ProdW    = LoadW + 10;
  // Wide enough for MaxAgents products of a full load by the weight.
  localparam int unsigned PenAccW  = ProdW + AgentW;
  localparam int unsigned OutW     = 32;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = OutW + LoadW + OutW;

  localparam logic [9:0] PenaltyWeight = 10'd1000;
  localparam logic [CfgW-1:0] AgentsInUseReset = CfgW'(MaxAgents);

  localparam logic [1:0] CmdCost     = 2'd0;
  localparam logic [1:0] CmdDemand   = 2'd1;
  localparam logic [1:0] CmdCapacity = 2'd2;
  localparam logic [1:0] CmdAssign   = 2'd3;

  typedef logic [LoadW-1:0] load_t;

endpackage

// ----- hw/rtl/assignment_fitness_eval.sv -----
// Top level of the assignment fitness evaluator: table memories, agent
// loads, penalty walk sequencer and result register. Depends on afe_pkg.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata agent,task_req,value; tuser command;
//                                              tlast last
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata fitness,cost_total,penalty_total;
//                                              tuser saturated
// cfg       in   cfg_we_i                      cfg_wdata_i agents_in_use
//
// Table writes may follow back to back while the block is idle.
// An assign is done in two steps: a registered read of both tables and the load,
// then the saturating updates. A last assign then walks the agents in use through
// the difference, multiply by 1000 and accumulate steps on one shared datapath,
// and forms the result once the result register can take it.
// Reset clears the loads (valid bits), the cost sum and the result valid, and sets 16 agents in use.
// A full result register stalls the block only when the next result is ready.
module assignment_fitness_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [afe_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] agent, [11:4] task_req, [27:12] value, [31:28] zero
  input  logic [afe_pkg::InDataW-1:0]      s_axis_tdata,
  // [1:0] command
  input  logic [1:0]                       s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] fitness, [55:32] cost_total, [87:56] penalty_total
  output logic [afe_pkg::OutDataW-1:0]     m_axis_tdata,
  // [0] saturated
  output logic [0:0]                       m_axis_tuser
);
  import afe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_DIFF = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  logic [CfgW-1:0] aiu_q;
  logic [CfgW-1:0] walk_n;

  logic [AgentW-1:0] in_agent;
  logic [TaskW-1:0]  in_task;
  logic [ValueW-1:0] in_value;
  logic [AddrW-1:0]  in_addr;
  logic              in_xfer;

  logic [ValueW-1:0] cost_mem [TableDepth];
  logic [ValueW-1:0] dem_mem  [TableDepth];
  logic [ValueW-1:0] cap_q    [MaxAgents];
  load_t             load_q   [MaxAgents];
  logic [MaxAgents-1:0] load_vld_q;

  logic [ValueW-1:0] cost_rd_q, dem_rd_q;
  load_t             load_rd_q;
  logic [AgentW-1:0] agent_q;
  logic              last_q;

  load_t cost_sum_q;
  logic [LoadW:0] cost_add, load_add;

  logic [AgentW-1:0] walk_q;
  load_t             walk_load;
  logic              walk_end;
  load_t             diff_q;
  logic [ProdW-1:0]  prod_q;
  logic [PenAccW-1:0] pen_q;

  logic [PenAccW:0] fit_sum;
  logic             pen_sat, fit_sat, fin_go;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_sat_q;

  assign in_agent = s_axis_tdata[AgentW-1:0];
  assign in_task  = s_axis_tdata[AgentW+TaskW-1:AgentW];
  assign in_value = s_axis_tdata[AgentW+TaskW+ValueW-1:AgentW+TaskW];
  assign in_addr  = {in_agent, in_task};

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign walk_n   = (aiu_q > CfgW'(MaxAgents)) ? CfgW'(MaxAgents) : aiu_q;
  assign walk_end = ({1'b0, walk_q} + (AgentW+1)'(1)) == (AgentW+1)'(walk_n);
  assign walk_load = load_vld_q[walk_q] ? load_q[walk_q] : '0;

  assign cost_add = {1'b0, cost_sum_q} + (LoadW+1)'(cost_rd_q);
  assign load_add = {1'b0, load_rd_q} + (LoadW+1)'(dem_rd_q);

  assign fit_sum = {1'b0, pen_q} + (PenAccW+1)'(cost_sum_q);
  assign pen_sat = |pen_q[PenAccW-1:OutW];
  assign fit_sat = |fit_sum[PenAccW:OutW];
  assign fin_go  = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

  // Table memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (in_xfer && s_axis_tuser == CmdCost) begin
      cost_mem[in_addr] <= in_value;
    end
    if (in_xfer && s_axis_tuser == CmdDemand) begin
      dem_mem[in_addr] <= in_value;
    end
    if (in_xfer && s_axis_tuser == CmdCapacity) begin
      cap_q[in_agent] <= in_value;
    end
    cost_rd_q <= cost_mem[in_addr];
    dem_rd_q  <= dem_mem[in_addr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer && s_axis_tuser == CmdAssign) state_d = S_ACC;
      S_ACC: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (walk_n == '0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_MUL;
      S_MUL:  state_d = S_ADD;
      S_ADD:  state_d = walk_end ? S_FIN : S_DIFF;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      aiu_q      <= AgentsInUseReset;
      load_vld_q <= '0;
      cost_sum_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        aiu_q <= cfg_wdata_i;
      end
      if (state_q == S_ACC) begin
        cost_sum_q <= cost_add[LoadW] ? '1 : cost_add[LoadW-1:0];
        load_vld_q[agent_q] <= 1'b1;
      end
      if (fin_go) begin
        load_vld_q <= '0;
        cost_sum_q <= '0;
        m_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      agent_q   <= in_agent;
      last_q    <= s_axis_tlast;
      load_rd_q <= load_vld_q[in_agent] ? load_q[in_agent] : '0;
    end
    if (state_q == S_ACC) begin
      load_q[agent_q] <= load_add[LoadW] ? '1 : load_add[LoadW-1:0];
      walk_q <= '0;
      pen_q  <= '0;
    end
    // Shared walk datapath: overload, weighted product, accumulate.
    if (state_q == S_DIFF) begin
      diff_q <= (walk_load > LoadW'(cap_q[walk_q])) ?
                walk_load - LoadW'(cap_q[walk_q]) : '0;
    end
    if (state_q == S_MUL) begin
      prod_q <= ProdW'(diff_q) * ProdW'(PenaltyWeight);
    end
    if (state_q == S_ADD) begin
      pen_q  <= pen_q + PenAccW'(prod_q);
      walk_q <= walk_q + AgentW'(1);
    end
    if (fin_go) begin
      m_data_q[OutW-1:0]            <= fit_sat ? '1 : fit_sum[OutW-1:0];
      m_data_q[OutW+LoadW-1:OutW]   <= cost_sum_q;
      m_data_q[OutDataW-1:OutW+LoadW] <= pen_sat ? '1 : pen_q[OutW-1:0];
      m_sat_q <= pen_sat || fit_sat;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_sat_q;

  // A new result only comes out of the final sequencer step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $rose(m_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside the final step");

  // Finishing a solution leaves no load and no cost behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> load_vld_q == '0 && cost_sum_q == '0)
    else $error("loads or cost sum not cleared after a result");

  // A saturated result reports the maximum fitness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[OutW-1:0] == '1)
    else $error("saturation flagged without maximum fitness");

  // Without saturation, fitness is exactly cost plus penalty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tdata[OutW-1:0] == m_axis_tdata[OutDataW-1:OutW+LoadW]
                              + OutW'(m_axis_tdata[OutW+LoadW-1:OutW]))
    else $error("fitness differs from cost plus penalty");

  // The walk never visits an agent beyond the agents in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIFF |-> {1'b0, walk_q} < (AgentW+1)'(walk_n))
    else $error("penalty walk past the agents in use");

endmodule
